@@ design/assert_macros.svh @@
// Assertion macros used by the lattice value noise core top level.
// They expect signals named clock and reset in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that the consequent holds whenever the antecedent holds.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Checks that a condition never holds.
`define ASSERT_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error(msg);

`endif

@@ design/lvn_pkg.sv @@
// Package for the lattice value noise core: widths, kind codes and prime table.
// No dependencies; used by every module of the block.
package lvn_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int COORD_W = 32;
   localparam int IDX_W = 32;
   localparam int T_W = 31;
   localparam int W_W = 34;
   localparam int Q_BITS = 30;
   localparam int HASH_W = 30;
   localparam int L1_W = 36;
   localparam int OUT_W = 38;
   localparam int KIND_W = 3;
   localparam int PSEL_W = 3;
   localparam int MIX_SHIFT = 13;

   localparam logic [IDX_W-1:0] ROW_STRIDE = 32'd51;

   localparam logic [KIND_W-1:0] KIND_1D_LIN    = 3'd0;
   localparam logic [KIND_W-1:0] KIND_1D_SMOOTH = 3'd1;
   localparam logic [KIND_W-1:0] KIND_2D_LIN    = 3'd2;
   localparam logic [KIND_W-1:0] KIND_2D_SMOOTH = 3'd3;
   localparam logic [KIND_W-1:0] KIND_RAW_1D    = 3'd4;
   localparam logic [KIND_W-1:0] KIND_RAW_2D    = 3'd5;

   typedef struct packed {
      logic [31:0] p0;
      logic [31:0] p1;
      logic [31:0] p2;
   } prime_type;

   typedef struct packed {
      logic                   valid;
      logic [KIND_W-1:0]      kind;
      logic signed [T_W-1:0]  tx;
      logic signed [T_W-1:0]  ty;
      logic [IDX_W-1:0]       idx;
   } front_type;

   function automatic prime_type prime_lookup(input logic [PSEL_W-1:0] sel);
      prime_type p;
      case (sel)
         3'd0: p = '{32'd15731, 32'd789221, 32'd1376312589};
         3'd1: p = '{32'd16097, 32'd788089, 32'd1370008667};
         3'd2: p = '{32'd16921, 32'd788089, 32'd1370008667};
         3'd3: p = '{32'd15373, 32'd784411, 32'd1379991589};
         default: p = '{32'd15661, 32'd787939, 32'd1378991399};
      endcase
      return p;
   endfunction

   function automatic logic is_noise_2d(input logic [KIND_W-1:0] kind);
      return (kind == KIND_2D_LIN) || (kind == KIND_2D_SMOOTH);
   endfunction

   function automatic logic is_noise(input logic [KIND_W-1:0] kind);
      return (kind == KIND_1D_LIN) || (kind == KIND_1D_SMOOTH) || is_noise_2d(kind);
   endfunction

   function automatic logic is_raw(input logic [KIND_W-1:0] kind);
      return (kind == KIND_RAW_1D) || (kind == KIND_RAW_2D);
   endfunction

endpackage

@@ design/lvn_front.sv @@
// Front end: splits the coordinates into integer and Q.30 fraction parts
// and forms the base lattice index. Depends on lvn_pkg.
module lvn_front #(
   parameter int FRAC_BITS = lvn_pkg::FRAC_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   in_valid,
   input  logic [lvn_pkg::KIND_W-1:0]             in_kind,
   input  logic signed [lvn_pkg::COORD_W-1:0]     in_x,
   input  logic signed [lvn_pkg::COORD_W-1:0]     in_y,
   output lvn_pkg::front_type                     out_beat
);

   localparam int SHIFT = lvn_pkg::Q_BITS - FRAC_BITS;
   localparam int MAG_W = lvn_pkg::COORD_W + 1;
   localparam int IW = lvn_pkg::IDX_W;
   localparam int TW = lvn_pkg::T_W;

   function automatic logic [IW+TW-1:0] split_coord(input logic signed [lvn_pkg::COORD_W-1:0] s);
      logic [MAG_W-1:0] mag;
      logic [MAG_W-1:0] imag;
      logic [MAG_W-1:0] fmag;
      logic [MAG_W-1:0] fsh;
      logic [IW-1:0]    ipart;
      logic [TW-1:0]    tpart;
      mag = s[lvn_pkg::COORD_W-1] ? (MAG_W'(0) - MAG_W'(s)) : MAG_W'(s);
      imag = mag >> FRAC_BITS;
      fmag = mag & ((MAG_W'(1) << FRAC_BITS) - MAG_W'(1));
      fsh = fmag << SHIFT;
      ipart = s[lvn_pkg::COORD_W-1] ? (IW'(0) - imag[IW-1:0]) : imag[IW-1:0];
      tpart = s[lvn_pkg::COORD_W-1] ? (TW'(0) - fsh[TW-1:0]) : fsh[TW-1:0];
      return {ipart, tpart};
   endfunction

   logic                              valid_a_ff;
   logic [lvn_pkg::KIND_W-1:0]        kind_a_ff;
   logic [IW-1:0]                     ix_a_ff;
   logic [IW-1:0]                     iy_a_ff;
   logic signed [TW-1:0]              tx_a_ff;
   logic signed [TW-1:0]              ty_a_ff;
   logic [IW+TW-1:0]                  split_x;
   logic [IW+TW-1:0]                  split_y;
   logic                              row_mode;
   logic [IW-1:0]                     idx_in;
   lvn_pkg::front_type                beat_ff;

   assign split_x = split_coord(in_x);
   assign split_y = split_coord(in_y);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
      end else begin
         valid_a_ff <= in_valid;
      end
      kind_a_ff <= in_kind;
      ix_a_ff <= split_x[IW+TW-1:TW];
      iy_a_ff <= split_y[IW+TW-1:TW];
      tx_a_ff <= split_x[TW-1:0];
      ty_a_ff <= split_y[TW-1:0];
   end

   assign row_mode = lvn_pkg::is_noise_2d(kind_a_ff) || (kind_a_ff == lvn_pkg::KIND_RAW_2D);

   always_comb begin
      idx_in = ix_a_ff;
      if (row_mode) begin
         idx_in = ix_a_ff + IW'(iy_a_ff * lvn_pkg::ROW_STRIDE);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff.valid <= 1'b0;
      end else begin
         beat_ff.valid <= valid_a_ff;
      end
      beat_ff.kind <= kind_a_ff;
      beat_ff.tx <= tx_a_ff;
      beat_ff.ty <= ty_a_ff;
      beat_ff.idx <= idx_in;
   end

   assign out_beat = beat_ff;

endmodule

@@ design/lvn_hash_lane.sv @@
// One lattice hash lane: shift-xor mix and cubic prime polynomial over
// four register stages, 32-bit wrap. Depends on lvn_pkg.
module lvn_hash_lane (
   input  logic                            clock,
   input  logic [lvn_pkg::IDX_W-1:0]       idx,
   input  logic [lvn_pkg::PSEL_W-1:0]      prime_set,
   output logic [lvn_pkg::HASH_W-1:0]      hash
);

   localparam int IW = lvn_pkg::IDX_W;

   lvn_pkg::prime_type   primes;
   logic [IW-1:0]        t1_ff;
   logic [IW-1:0]        t2_ff;
   logic [IW-1:0]        t3_ff;
   logic [IW-1:0]        tt2_ff;
   logic [IW-1:0]        m3_ff;
   logic [IW-1:0]        h_in;
   logic [lvn_pkg::HASH_W-1:0] hash_ff;

   assign primes = lvn_pkg::prime_lookup(prime_set);
   assign h_in = IW'(t3_ff * m3_ff) + primes.p2;

   always_ff @(posedge clock) begin
      t1_ff <= (idx << lvn_pkg::MIX_SHIFT) ^ idx;
      tt2_ff <= IW'(t1_ff * t1_ff);
      t2_ff <= t1_ff;
      m3_ff <= IW'(tt2_ff * primes.p0) + primes.p1;
      t3_ff <= t2_ff;
      hash_ff <= h_in[lvn_pkg::HASH_W-1:0];
   end

   assign hash = hash_ff;

endmodule

@@ design/lvn_weight.sv @@
// Interpolation weight: linear passes the Q.30 fraction through, smoothstep
// forms 3t^2 - 2t^3 in Q.30 over four stages. Depends on lvn_pkg.
module lvn_weight (
   input  logic                               clock,
   input  logic signed [lvn_pkg::T_W-1:0]     t,
   input  logic                               smooth,
   output logic signed [lvn_pkg::W_W-1:0]     w
);

   localparam int TW = lvn_pkg::T_W;
   localparam int WW = lvn_pkg::W_W;
   localparam int Q = lvn_pkg::Q_BITS;
   localparam int SQ_W = 2 * TW;
   localparam int U_W = Q + 3;
   localparam int P_W = Q + U_W;
   localparam logic signed [WW-1:0] THREE_Q = WW'(3) << Q;

   logic signed [SQ_W-1:0]  tsq;
   logic signed [SQ_W-1:0]  tsq1_ff;
   logic signed [TW-1:0]    t1_ff;
   logic signed [TW-1:0]    t2_ff;
   logic signed [TW-1:0]    t3_ff;
   logic                    sm1_ff;
   logic                    sm2_ff;
   logic                    sm3_ff;
   logic [Q-1:0]            sq2_ff;
   logic [U_W-1:0]          u2_ff;
   logic signed [WW-1:0]    u_in;
   logic [P_W-1:0]          prod3_ff;
   logic signed [WW-1:0]    w_ff;

   assign tsq = SQ_W'(t) * SQ_W'(t);
   assign u_in = THREE_Q - (WW'(t1_ff) <<< 1);

   always_ff @(posedge clock) begin
      tsq1_ff <= tsq;
      t1_ff <= t;
      sm1_ff <= smooth;
      sq2_ff <= tsq1_ff[2*Q-1:Q];
      u2_ff <= u_in[U_W-1:0];
      t2_ff <= t1_ff;
      sm2_ff <= sm1_ff;
      prod3_ff <= P_W'(sq2_ff) * P_W'(u2_ff);
      t3_ff <= t2_ff;
      sm3_ff <= sm2_ff;
      if (sm3_ff) begin
         w_ff <= WW'({1'b0, prod3_ff[P_W-1:Q]});
      end else begin
         w_ff <= WW'(t3_ff);
      end
   end

   assign w = w_ff;

endmodule

@@ design/lvn_blend.sv @@
// Blend a + floor(w * (b - a) / 2^30) with an exact floor, over three
// stages: difference, product, shift and add. Depends on lvn_pkg.
module lvn_blend #(
   parameter int IN_W = 32,
   parameter int OUT_W = 36
) (
   input  logic                               clock,
   input  logic signed [IN_W-1:0]             a,
   input  logic signed [IN_W-1:0]             b,
   input  logic signed [lvn_pkg::W_W-1:0]     w,
   output logic signed [OUT_W-1:0]            r
);

   localparam int D_W = IN_W + 1;
   localparam int P_W = D_W + lvn_pkg::W_W;

   logic signed [D_W-1:0]           d1_ff;
   logic signed [IN_W-1:0]          a1_ff;
   logic signed [IN_W-1:0]          a2_ff;
   logic signed [lvn_pkg::W_W-1:0]  w1_ff;
   logic signed [P_W-1:0]           p2_ff;
   logic signed [P_W-1:0]           p_shift;
   logic signed [OUT_W-1:0]         r_ff;

   assign p_shift = p2_ff >>> lvn_pkg::Q_BITS;

   always_ff @(posedge clock) begin
      d1_ff <= D_W'(b) - D_W'(a);
      a1_ff <= a;
      w1_ff <= w;
      p2_ff <= P_W'(d1_ff) * P_W'(w1_ff);
      a2_ff <= a1_ff;
      r_ff <= OUT_W'(a2_ff) + p_shift[OUT_W-1:0];
   end

   assign r = r_ff;

endmodule

@@ design/lattice_value_noise_core.sv @@
// Top level of the lattice value noise core: front end, four hash lanes,
// two weight units and three blend units. Depends on lvn_pkg and all lvn_ modules.
//
// Usage:
// An item (req_kind, req_x_coord, req_y_coord) is taken at a rising edge with
// req_start high and busy low. busy is never raised: a new item may enter in
// every cycle, and the pipeline holds up to thirteen items in flight.
// Each result appears on rsp_noise_value for one cycle with rsp_valid high,
// in order. The receiver cannot stall, so no beat is ever held back.
// Latency is set by the chain: coordinate split, lattice index, four hash
// stages (three 32-bit multiplies), three blend stages for the north/south
// pairs, three more for the east/west blend, and the output register.
// The prime_set register is written through the csr_ channel (csr_ready is
// always high) and should only change while no item is in flight.
// A synchronous reset empties the pipeline and sets prime_set to zero.
module lattice_value_noise_core #(
   parameter int FRAC_BITS = lvn_pkg::FRAC_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_start,
   output logic                                  busy,
   input  logic [lvn_pkg::KIND_W-1:0]            req_kind,
   input  logic signed [lvn_pkg::COORD_W-1:0]    req_x_coord,
   input  logic signed [lvn_pkg::COORD_W-1:0]    req_y_coord,
   output logic                                  rsp_valid,
   output logic signed [lvn_pkg::OUT_W-1:0]      rsp_noise_value,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [lvn_pkg::PSEL_W-1:0]            csr_prime_set
);

   `include "assert_macros.svh"

   localparam int IW = lvn_pkg::IDX_W;
   localparam int DEPTH = 10;
   localparam int WX_DLY = 3;

   logic [lvn_pkg::PSEL_W-1:0]     prime_set_ff;
   lvn_pkg::front_type             fb;
   logic [IW-1:0]                  idx_lane [4];
   logic [lvn_pkg::HASH_W-1:0]     hash_lane [4];
   logic signed [lvn_pkg::W_W-1:0] wx;
   logic signed [lvn_pkg::W_W-1:0] wy;
   logic signed [lvn_pkg::W_W-1:0] w1;
   logic signed [lvn_pkg::W_W-1:0] w2;
   logic signed [lvn_pkg::W_W-1:0] wx_ff [1:WX_DLY];
   logic [lvn_pkg::KIND_W-1:0]     kind_ff [1:DEPTH];
   logic                           valid_ff [1:DEPTH];
   logic signed [31:0]             lane_val [4];
   logic signed [lvn_pkg::L1_W-1:0] west;
   logic signed [lvn_pkg::L1_W-1:0] east;
   logic signed [lvn_pkg::OUT_W-1:0] blended;
   logic                           rsp_valid_ff;
   logic signed [lvn_pkg::OUT_W-1:0] rsp_noise_value_ff;

   assign busy = 1'b0;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         prime_set_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         prime_set_ff <= csr_prime_set;
      end
   end

   lvn_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_start && !busy),
      .in_kind  (req_kind),
      .in_x     (req_x_coord),
      .in_y     (req_y_coord),
      .out_beat (fb)
   );

   assign idx_lane[0] = fb.idx;
   assign idx_lane[1] = fb.idx + IW'(1);
   assign idx_lane[2] = fb.idx + lvn_pkg::ROW_STRIDE;
   assign idx_lane[3] = fb.idx + lvn_pkg::ROW_STRIDE + IW'(1);

   for (genvar g = 0; g < 4; g++) begin : g_lane
      lvn_hash_lane u_lane (
         .clock     (clock),
         .idx       (idx_lane[g]),
         .prime_set (prime_set_ff),
         .hash      (hash_lane[g])
      );
      assign lane_val[g] = 32'({2'b00, hash_lane[g]});
   end

   lvn_weight u_weight_x (
      .clock  (clock),
      .t      (fb.tx),
      .smooth (fb.kind[0]),
      .w      (wx)
   );

   lvn_weight u_weight_y (
      .clock  (clock),
      .t      (fb.ty),
      .smooth (fb.kind[0]),
      .w      (wy)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 1; k <= DEPTH; k++) begin
            valid_ff[k] <= 1'b0;
         end
      end else begin
         valid_ff[1] <= fb.valid;
         for (int k = 2; k <= DEPTH; k++) begin
            valid_ff[k] <= valid_ff[k-1];
         end
      end
      kind_ff[1] <= fb.kind;
      for (int k = 2; k <= DEPTH; k++) begin
         kind_ff[k] <= kind_ff[k-1];
      end
      wx_ff[1] <= wx;
      for (int k = 2; k <= WX_DLY; k++) begin
         wx_ff[k] <= wx_ff[k-1];
      end
   end

   // A zero weight makes a blend return its first input, which routes the
   // 1D and raw lattice values through the same units.
   assign w1 = lvn_pkg::is_noise_2d(kind_ff[4]) ? wy : '0;
   assign w2 = lvn_pkg::is_noise(kind_ff[7]) ? wx_ff[WX_DLY] : '0;

   lvn_blend #(.IN_W(32), .OUT_W(lvn_pkg::L1_W)) u_blend_west (
      .clock (clock),
      .a     (lane_val[0]),
      .b     (lane_val[2]),
      .w     (w1),
      .r     (west)
   );

   lvn_blend #(.IN_W(32), .OUT_W(lvn_pkg::L1_W)) u_blend_east (
      .clock (clock),
      .a     (lane_val[1]),
      .b     (lane_val[3]),
      .w     (w1),
      .r     (east)
   );

   lvn_blend #(.IN_W(lvn_pkg::L1_W), .OUT_W(lvn_pkg::OUT_W)) u_blend_final (
      .clock (clock),
      .a     (west),
      .b     (east),
      .w     (w2),
      .r     (blended)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= valid_ff[DEPTH];
      end
      if (kind_ff[DEPTH] > lvn_pkg::KIND_RAW_2D) begin
         rsp_noise_value_ff <= '0;
      end else begin
         rsp_noise_value_ff <= blended;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_noise_value = rsp_noise_value_ff;

   `ASSERT_IMPLIES(a_latency, req_start && !busy, ##13 rsp_valid, "result beat missing")
   `ASSERT_IMPLIES(a_no_spurious, rsp_valid, $past(req_start && !busy, 13), "unexpected result beat")
   `ASSERT_NEVER(a_never_busy, busy, "busy raised")
   `ASSERT_IMPLIES(a_raw_unit, valid_ff[DEPTH] && lvn_pkg::is_raw(kind_ff[DEPTH]), ##1 (rsp_noise_value[lvn_pkg::OUT_W-1:lvn_pkg::Q_BITS] == '0), "raw hash out of range")

endmodule
